/* design/lpt_pkg.sv */
// Shared types, register indexes and helpers of the laser plane triangulation block.
package lpt_pkg;

  // Width of the divisor magnitude and of the partial remainder.
  localparam int unsigned MD_W = 58;
  // Quotient bits produced by the divider, one per stage.
  localparam int unsigned Q_W = 32;
  // Cycles from an accepted item to its result strobe.
  localparam int unsigned LATENCY = 41;
  localparam int unsigned CFG_IDX_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INV_R0C0  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_R0C1  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_R0C2  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_R1C1  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_R1C2  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_SX  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_SY  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFS = 4'd7;

  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_PARALLEL  = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] u_pixel;
    logic [15:0] v_pixel;
    logic        last_in_set;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_cam;
    logic signed [31:0] y_cam;
    logic signed [31:0] z_cam;
    status_e            point_status;
    logic               last_out;
  } res_item_t;

  typedef struct packed {
    logic signed [31:0] inv_row0_col0;
    logic signed [31:0] inv_row0_col1;
    logic signed [31:0] inv_row0_col2;
    logic signed [31:0] inv_row1_col1;
    logic signed [31:0] inv_row1_col2;
    logic signed [31:0] plane_slope_x;
    logic signed [31:0] plane_slope_y;
    logic signed [31:0] plane_offset;
  } cfg_t;

  // Per-item values that ride along the pipeline.
  typedef struct packed {
    logic signed [31:0] xn;
    logic signed [31:0] yn;
    logic               sat;
    logic               par;
    logic               neg;
    logic               last;
  } side_t;

  // State of one item inside the divider.
  typedef struct packed {
    logic [MD_W-1:0] rem;
    logic [Q_W-1:0]  low;
    logic [Q_W-1:0]  quo;
    logic [MD_W-1:0] md;
    logic            ovf;
    side_t           side;
  } div_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } clamp_t;

  // Clamp a wide signed value to 32 bits and flag the clamp.
  function automatic clamp_t clamp32(input logic signed [65:0] x);
    clamp_t r;
    r.sat = 1'b0;
    r.val = 32'(x);
    if (x > MAX32) begin
      r.sat = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (x < MIN32) begin
      r.sat = 1'b1;
      r.val = 32'sh8000_0000;
    end
    return r;
  endfunction

endpackage

/* design/laser_plane_pixel_triangulation.sv */
// Top level of the laser plane triangulation block: registers, pipeline and divider chain.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------
//   input    | start / busy              | in_item_i (u, v, last_in_set)
//   result   | res_valid_o (strobe)      | res_item_o (x, y, z, status, last)
//   config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item is taken every cycle.
// The latency is set by the 32-stage restoring divider for the depth, one
// quotient bit per stage, plus two normalization, four denominator and three
// output stages. busy stays low and config writes are always taken.
// Reset clears the configuration registers and the valid bits; no clearing pass is needed.
// The receiver cannot stall, so results leave in the order items came in.
module laser_plane_pixel_triangulation import lpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item_i,
  output logic                 res_valid_o,
  output res_item_t            res_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  cfg_t  cfg_q;
  logic  front_valid, denom_valid;
  side_t front_side;
  logic  div_valid [Q_W+1];
  div_t  div_data  [Q_W+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration register file; writes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_INV_R0C0:  cfg_q.inv_row0_col0 <= cfg_data_i;
        REG_INV_R0C1:  cfg_q.inv_row0_col1 <= cfg_data_i;
        REG_INV_R0C2:  cfg_q.inv_row0_col2 <= cfg_data_i;
        REG_INV_R1C1:  cfg_q.inv_row1_col1 <= cfg_data_i;
        REG_INV_R1C2:  cfg_q.inv_row1_col2 <= cfg_data_i;
        REG_PLANE_SX:  cfg_q.plane_slope_x <= cfg_data_i;
        REG_PLANE_SY:  cfg_q.plane_slope_y <= cfg_data_i;
        REG_PLANE_OFS: cfg_q.plane_offset  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Normalized camera coordinates.
  lpt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .valid_o (front_valid),
    .side_o  (front_side)
  );

  // Plane denominator and divider operands.
  lpt_denom u_denom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .side_i  (front_side),
    .cfg_i   (cfg_q),
    .valid_o (denom_valid),
    .div_o   (div_data[0])
  );

  assign div_valid[0] = denom_valid;

  // Divider chain, most significant quotient bit first.
  for (genvar g = 0; g < Q_W; g++) begin : g_div
    lpt_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[g]),
      .div_i   (div_data[g]),
      .valid_o (div_valid[g+1]),
      .div_o   (div_data[g+1])
    );
  end

  // Depth clamp, scaling and status.
  lpt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid[Q_W]),
    .div_i   (div_data[Q_W]),
    .valid_o (res_valid_o),
    .res_o   (res_item_o)
  );

  // Every result strobe traces back to an item accepted one latency earlier.
  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted item");

  // A parallel ray returns the origin.
  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_item_o.point_status == ST_PARALLEL) |->
    (res_item_o.x_cam == '0 && res_item_o.y_cam == '0 && res_item_o.z_cam == '0))
    else $error("parallel ray result is not zero");

  // A plane through the camera center gives zero depth.
  a_zero_offset_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && cfg_q.plane_offset == '0) |-> (res_item_o.z_cam == '0))
    else $error("nonzero depth for a plane with zero offset");

endmodule

/* design/lpt_front.sv */
// Pixel to normalized camera coordinates: two pipeline stages.
module lpt_front import lpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output logic     valid_o,
  output side_t    side_o
);

  logic               v1_q, v2_q;
  logic signed [47:0] p00_q, p01_q, p11_q;
  logic signed [47:0] p00_d, p01_d, p11_d;
  logic               last1_q;
  logic signed [50:0] sx, sy;
  clamp_t             cx, cy;
  side_t              side_d, side_q;

  // Products of the pixel coordinates with the inverse intrinsic entries.
  always_comb begin
    p00_d = $signed(cfg_i.inv_row0_col0) * $signed({1'b0, item_i.u_pixel});
    p01_d = $signed(cfg_i.inv_row0_col1) * $signed({1'b0, item_i.v_pixel});
    p11_d = $signed(cfg_i.inv_row1_col1) * $signed({1'b0, item_i.v_pixel});
  end

  // Sums with 32 fraction bits, rounded to 24 fraction bits and clamped.
  always_comb begin
    sx = 51'(p00_q) + 51'(p01_q) + (51'($signed(cfg_i.inv_row0_col2)) <<< 4) + 51'sd128;
    sy = 51'(p11_q) + (51'($signed(cfg_i.inv_row1_col2)) <<< 4) + 51'sd128;
    cx = clamp32(66'(sx >>> 8));
    cy = clamp32(66'(sy >>> 8));
    side_d.xn   = cx.val;
    side_d.yn   = cy.val;
    side_d.sat  = cx.sat | cy.sat;
    side_d.par  = 1'b0;
    side_d.neg  = 1'b0;
    side_d.last = last1_q;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    p00_q   <= p00_d;
    p01_q   <= p01_d;
    p11_q   <= p11_d;
    last1_q <= item_i.last_in_set;
    side_q  <= side_d;
  end

  assign valid_o = v2_q;
  assign side_o  = side_q;

endmodule

/* design/lpt_denom.sv */
// Plane denominator and divider operand setup: four pipeline stages.
module lpt_denom import lpt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  side_t side_i,
  input  cfg_t  cfg_i,
  output logic  valid_o,
  output div_t  div_o
);

  logic [3:0]              v_q;
  logic signed [63:0]      pa0_q, pa1_q;
  side_t                   s1_q, s2_q, s3_q, s3_d;
  logic signed [MD_W-1:0]  d_q, d_d;
  logic [MD_W-1:0]         md_q, md_d;
  logic [31:0]             na_q, na_d;
  logic [31:0]             nhi;
  div_t                    div_d, div_q;

  // Denominator from floored plane products, minus one in Q.32.
  always_comb begin
    d_d = MD_W'(pa0_q >>> 8) + MD_W'(pa1_q >>> 8) - (58'sd1 <<< 32);
  end

  // Magnitudes and sign of the quotient, parallel ray check.
  always_comb begin
    s3_d     = s2_q;
    s3_d.par = (d_q == '0);
    md_d     = d_q[MD_W-1] ? MD_W'(-d_q) : MD_W'(d_q);
    na_d     = cfg_i.plane_offset[31] ? 32'(-cfg_i.plane_offset) : 32'(cfg_i.plane_offset);
    s3_d.neg = (cfg_i.plane_offset != '0) && (cfg_i.plane_offset[31] == d_q[MD_W-1]);
  end

  // Rounded numerator (|a2| << 32) + |d|/2 split into its upper and lower words.
  always_comb begin
    nhi       = na_q + 32'(md_q[MD_W-1:33]);
    div_d.rem = MD_W'(nhi);
    div_d.low = md_q[32:1];
    div_d.quo = '0;
    div_d.md  = md_q;
    div_d.ovf = (MD_W'(nhi) >= md_q);
    div_d.side = s3_q;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pa0_q <= $signed(cfg_i.plane_slope_x) * $signed(side_i.xn);
    pa1_q <= $signed(cfg_i.plane_slope_y) * $signed(side_i.yn);
    s1_q  <= side_i;
    d_q   <= d_d;
    s2_q  <= s1_q;
    md_q  <= md_d;
    na_q  <= na_d;
    s3_q  <= s3_d;
    div_q <= div_d;
  end

  assign valid_o = v_q[3];
  assign div_o   = div_q;

endmodule

/* design/lpt_div_stage.sv */
// One restoring division stage: one quotient bit per cycle.
module lpt_div_stage import lpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  div_t div_i,
  output logic valid_o,
  output div_t div_o
);

  logic          v_q;
  logic [MD_W:0] trial;
  logic          take;
  div_t          div_d, div_q;

  // Bring down the next numerator bit and subtract the divisor if it fits.
  always_comb begin
    trial     = {div_i.rem, div_i.low[Q_W-1]};
    take      = (trial >= {1'b0, div_i.md});
    div_d     = div_i;
    div_d.rem = take ? MD_W'(trial - {1'b0, div_i.md}) : MD_W'(trial);
    div_d.low = {div_i.low[Q_W-2:0], 1'b0};
    div_d.quo = {div_i.quo[Q_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign valid_o = v_q;
  assign div_o   = div_q;

endmodule

/* design/lpt_back.sv */
// Depth clamp, ray scaling, rounding and status: three pipeline stages.
module lpt_back import lpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  div_t      div_i,
  output logic      valid_o,
  output res_item_t res_o
);

  logic [2:0]         v_q;
  logic [31:0]        lim, qs;
  logic               over;
  logic signed [31:0] zc_d, zc1_q, zc2_q;
  logic               sat_d;
  side_t              s1_d, s1_q, s2_q;
  logic signed [63:0] px_q, py_q;
  clamp_t             cx, cy;
  res_item_t          res_d, res_q;

  // Clamp the quotient to the signed range and apply the sign; a parallel ray gives zero.
  always_comb begin
    lim   = div_i.side.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    over  = div_i.ovf || (div_i.quo > lim);
    qs    = over ? lim : div_i.quo;
    sat_d = div_i.side.sat | (over & ~div_i.side.par);
    s1_d     = div_i.side;
    s1_d.sat = sat_d;
    if (div_i.side.par) begin
      zc_d = '0;
    end else if (div_i.side.neg) begin
      zc_d = $signed(-qs);
    end else begin
      zc_d = $signed(qs);
    end
  end

  // Round the scaled coordinates to Q16.16 and build the status.
  always_comb begin
    cx = clamp32((66'(px_q) + 66'sd8388608) >>> 24);
    cy = clamp32((66'(py_q) + 66'sd8388608) >>> 24);
    res_d.x_cam    = cx.val;
    res_d.y_cam    = cy.val;
    res_d.z_cam    = zc2_q;
    res_d.last_out = s2_q.last;
    if (s2_q.par) begin
      res_d.point_status = ST_PARALLEL;
    end else if (s2_q.sat | cx.sat | cy.sat) begin
      res_d.point_status = ST_SATURATED;
    end else begin
      res_d.point_status = ST_VALID;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    zc1_q    <= zc_d;
    s1_q     <= s1_d;
    px_q     <= s1_q.xn * zc1_q;
    py_q     <= s1_q.yn * zc1_q;
    zc2_q    <= zc1_q;
    s2_q     <= s1_q;
    res_q    <= res_d;
  end

  assign valid_o = v_q[2];
  assign res_o   = res_q;

endmodule
